/* rtl/text_terminal_screen_writer_assert.svh */
// assertion macros shared by the terminal writer rtl
`ifndef TEXT_TERMINAL_SCREEN_WRITER_ASSERT_SVH
`define TEXT_TERMINAL_SCREEN_WRITER_ASSERT_SVH

// condition holds at every edge outside reset
`define TTSW_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition implies consequence in the same cycle
`define TTSW_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define TTSW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ttsw_pkg.sv */
package ttsw_pkg;

  // screen geometry
  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int CELLS = COLS * ROWS;

  // widths
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int CHAR_W     = 8;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int CUR_ADDR_W = 11;
  localparam int SWEEP_W    = $clog2(COLS);

  typedef logic [1:0] op_t;

  // operation codes
  localparam op_t OP_WRITE = 2'd0;
  localparam op_t OP_READ  = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;

  // terminal byte codes
  localparam logic [CHAR_W-1:0] CH_BS        = 8'd8;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'd10;
  localparam logic [CHAR_W-1:0] CH_VT        = 8'd11;
  localparam logic [CHAR_W-1:0] CH_FF        = 8'd12;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'd13;
  localparam logic [CHAR_W-1:0] CH_LAST_CTRL = 8'd31;
  localparam logic [CHAR_W-1:0] BLANK        = 8'h20;

endpackage

/* rtl/ttsw_ram.sv */
module ttsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/text_terminal_screen_writer.sv */
// Character terminal over an 80 by 25 text screen store.
// Input channel (in_valid / in_stall) carries one item: operation, byte_in,
// read_row, read_col. Operation write feeds one terminal byte (newline,
// carriage return, backspace, printable store with line wrap and scroll),
// read returns one cell, clear blanks the screen and homes the cursor.
// Output channel (out_valid / out_stall) returns one item per input item:
// cell_char and the cursor after the step, with its linear address.
// An item is accepted in the idle state and executed in the execute state
// that follows; a read passes through a further response state for the
// registered memory read. A printable byte that lands on a row not written
// since reset, clear or scroll first blanks that row, one cell a cycle.
// Scrolling itself only moves the top row pointer and costs nothing extra.
// The result waits in an output register; a stalled receiver holds it and
// the block takes one more item, which then waits in execute (a read in its
// response state) until the output register frees.
// Reset (rst, synchronous) homes the cursor and marks all rows blank; no
// pass over the memory is needed, so an item is accepted right away.
module text_terminal_screen_writer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ttsw_pkg::op_t                   operation,
  input  logic [ttsw_pkg::CHAR_W-1:0]     byte_in,
  input  logic [ttsw_pkg::ROW_W-1:0]      read_row,
  input  logic [ttsw_pkg::COL_W-1:0]      read_col,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ttsw_pkg::CHAR_W-1:0]     cell_char,
  output logic [ttsw_pkg::COL_W-1:0]      cursor_col,
  output logic [ttsw_pkg::ROW_W-1:0]      cursor_row,
  output logic [ttsw_pkg::CUR_ADDR_W-1:0] cursor_address
);

  localparam int AW  = ttsw_pkg::ADDR_W;
  localparam int CW  = ttsw_pkg::COL_W;
  localparam int RW  = ttsw_pkg::ROW_W;
  localparam int SW  = ttsw_pkg::SWEEP_W;
  localparam int CAW = ttsw_pkg::CUR_ADDR_W;
  localparam int NR  = ttsw_pkg::ROWS;

  localparam logic [CW-1:0] COLS_C     = CW'(ttsw_pkg::COLS);
  localparam logic [RW-1:0] ROWS_C     = RW'(ttsw_pkg::ROWS);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ttsw_pkg::ROWS - 1);
  localparam logic [RW:0]   ROWS_X     = (RW + 1)'(ttsw_pkg::ROWS);
  localparam logic [SW-1:0] SWEEP_LAST = SW'(ttsw_pkg::COLS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]               state;
  logic [CW-1:0]            cur_x;
  logic [RW-1:0]            cur_y;
  logic [RW-1:0]            top;
  logic [NR-1:0]            row_valid;
  logic                     swept;
  logic [SW-1:0]            sweep_cnt;
  logic [AW-1:0]            sweep_base;
  logic                     rd_live;
  logic                     rd_range;

  // latched item
  ttsw_pkg::op_t            op;
  logic [ttsw_pkg::CHAR_W-1:0] ch;
  logic [RW-1:0]            rrow;
  logic [CW-1:0]            rcol;

  logic                     accepted;
  logic                     slot_free;
  logic                     is_store;
  logic                     wrap;
  logic                     do_nl;
  logic                     scroll;
  logic [CW-1:0]            x_next;
  logic [RW-1:0]            y_next;
  logic [RW-1:0]            top_next;
  logic [RW-1:0]            top_inc;
  logic [CW-1:0]            store_col;
  logic [RW:0]              tgt_sum;
  logic [RW-1:0]            tgt_row;
  logic [AW-1:0]            tgt_base;
  logic                     need_sweep;
  logic                     exec_fire;
  logic                     read_issue;
  logic                     resp_fire;
  logic [RW:0]              rd_sum;
  logic [RW-1:0]            rd_row;
  logic                     in_range;
  logic [NR-1:0]            row_valid_next;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [ttsw_pkg::CHAR_W-1:0] ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [ttsw_pkg::CHAR_W-1:0] ram_rdata;

  assign in_stall  = (state != S_IDLE);
  assign accepted  = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  // byte decode and cursor motion
  always_comb begin
    is_store = (op == ttsw_pkg::OP_WRITE) && (ch > ttsw_pkg::CH_LAST_CTRL);
    wrap     = is_store && (cur_x >= COLS_C);
    do_nl    = (op == ttsw_pkg::OP_WRITE) &&
               ((ch == ttsw_pkg::CH_LF) || (ch == ttsw_pkg::CH_VT) ||
                (ch == ttsw_pkg::CH_FF) || wrap);
    scroll   = do_nl && (cur_y == LAST_ROW);
    top_inc  = (top == LAST_ROW) ? '0 : top + RW'(1);

    x_next   = cur_x;
    y_next   = cur_y;
    top_next = top;
    if (op == ttsw_pkg::OP_CLEAR) begin
      x_next   = '0;
      y_next   = '0;
      top_next = '0;
    end else if (op == ttsw_pkg::OP_WRITE) begin
      if (do_nl) begin
        x_next   = '0;
        y_next   = scroll ? cur_y : cur_y + RW'(1);
        top_next = scroll ? top_inc : top;
      end
      priority if (ch == ttsw_pkg::CH_CR) begin
        x_next = '0;
      end else if (ch == ttsw_pkg::CH_BS) begin
        if (cur_x > COLS_C) begin
          x_next = COLS_C - CW'(1);
        end else if (cur_x != '0) begin
          x_next = cur_x - CW'(1);
        end
      end else if (is_store) begin
        x_next = (wrap ? '0 : cur_x) + CW'(1);
      end else begin
        x_next = x_next;
      end
    end
    store_col = wrap ? '0 : cur_x;
  end

  // physical row of the store target, rows kept as a ring from top
  always_comb begin
    tgt_sum  = {1'b0, top_next} + {1'b0, y_next};
    tgt_row  = (tgt_sum >= ROWS_X) ? RW'(tgt_sum - ROWS_X) : RW'(tgt_sum);
    tgt_base = AW'(tgt_row) * AW'(ttsw_pkg::COLS);
  end

  // physical address of a read
  always_comb begin
    in_range = (rrow < ROWS_C) && (rcol < COLS_C);
    rd_sum   = {1'b0, top} + {1'b0, rrow};
    rd_row   = (rd_sum >= ROWS_X) ? RW'(rd_sum - ROWS_X) : RW'(rd_sum);
    ram_raddr = AW'(rd_row) * AW'(ttsw_pkg::COLS) + AW'(rcol);
  end

  // a store into a stale or freshly scrolled row blanks the row first
  assign need_sweep = is_store && !swept && (scroll || !row_valid[tgt_row]);
  assign exec_fire  = (state == S_EXEC) && (op != ttsw_pkg::OP_READ) &&
                      !need_sweep && slot_free;
  assign read_issue = (state == S_EXEC) && (op == ttsw_pkg::OP_READ);
  assign resp_fire  = (state == S_RESP) && slot_free;

  // row valid bits: clear drops all, scroll drops the new bottom row, a store marks its row
  always_comb begin
    row_valid_next = row_valid;
    if (exec_fire) begin
      if (op == ttsw_pkg::OP_CLEAR) begin
        row_valid_next = '0;
      end else begin
        if (scroll) begin
          row_valid_next[top] = 1'b0;
        end
        if (is_store) begin
          row_valid_next[tgt_row] = 1'b1;
        end
      end
    end
  end

  // memory write port: row blanking or character store
  always_comb begin
    ram_we    = (state == S_SWEEP) || (exec_fire && is_store);
    ram_waddr = tgt_base + AW'(store_col);
    ram_wdata = ch;
    if (state == S_SWEEP) begin
      ram_waddr = sweep_base + AW'(sweep_cnt);
      ram_wdata = ttsw_pkg::BLANK;
    end
  end

  ttsw_ram #(
    .WIDTH (ttsw_pkg::CHAR_W),
    .DEPTH (ttsw_pkg::CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (read_issue),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // item latch
  always_ff @(posedge clk) begin
    if (accepted) begin
      op   <= operation;
      ch   <= byte_in;
      rrow <= read_row;
      rcol <= read_col;
    end
  end

  // sequencer and cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_x     <= '0;
      cur_y     <= '0;
      top       <= '0;
      row_valid <= '0;
      swept     <= 1'b0;
      sweep_cnt <= '0;
    end else begin
      row_valid <= row_valid_next;
      unique case (state)
        S_IDLE: begin
          if (accepted) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (read_issue) begin
            state <= S_RESP;
          end else if (need_sweep) begin
            sweep_cnt <= '0;
            state     <= S_SWEEP;
          end else if (exec_fire) begin
            cur_x <= x_next;
            cur_y <= y_next;
            top   <= top_next;
            swept <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + SW'(1);
          if (sweep_cnt == SWEEP_LAST) begin
            swept <= 1'b1;
            state <= S_EXEC;
          end
        end
        S_RESP: begin
          if (resp_fire) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // sweep base and read status
  always_ff @(posedge clk) begin
    if ((state == S_EXEC) && need_sweep) begin
      sweep_base <= tgt_base;
    end
    if (read_issue) begin
      rd_range <= in_range;
      rd_live  <= in_range && row_valid[rd_row];
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire || resp_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (exec_fire) begin
      cell_char      <= '0;
      cursor_col     <= x_next;
      cursor_row     <= y_next;
      cursor_address <= CAW'(y_next) * CAW'(ttsw_pkg::COLS) + CAW'(x_next);
    end else if (resp_fire) begin
      cell_char      <= rd_live ? ram_rdata : (rd_range ? ttsw_pkg::BLANK : '0);
      cursor_col     <= cur_x;
      cursor_row     <= cur_y;
      cursor_address <= CAW'(cur_y) * CAW'(ttsw_pkg::COLS) + CAW'(cur_x);
    end
  end

  `include "text_terminal_screen_writer_assert.svh"

  `TTSW_ASSERT_ALWAYS(a_cursor_range, clk, rst, (cur_x <= COLS_C) && (cur_y < ROWS_C) && (top < ROWS_C), "cursor or top row out of range")
  `TTSW_ASSERT_IMPLIES(a_store_clean_row, clk, rst, ram_we && (state == S_EXEC), swept || (row_valid[tgt_row] && !scroll), "store into a row that was not blanked")
  `TTSW_ASSERT_NEXT(a_sweep_return, clk, rst, (state == S_SWEEP) && (sweep_cnt == SWEEP_LAST), (state == S_EXEC) && swept, "row blanking did not return to execute")
  `TTSW_ASSERT_NEXT(a_accept_exec, clk, rst, accepted, state == S_EXEC, "accepted item not executed")

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;

  // operation code the block leaves unused
  localparam ttsw_pkg::op_t OP_UNUSED = 2'd3;
  localparam logic [ttsw_pkg::CHAR_W-1:0] CH_ESC = 8'd27;

  localparam int RANDOM_OPS      = 1800;
  localparam int LONG_HOLD_AT    = 500;
  localparam int LONG_HOLD_LEN   = 300;
  localparam int DRAIN_LATENCY   = 200;
  localparam int CYCLE_LIMIT     = 800000;

  typedef enum {
    RUN_SCROLL, RUN_WRAP, RUN_WRAP_BS, RUN_TEXT, RUN_LINES,
    RUN_EDIT, RUN_READS, RUN_CLEAR, RUN_NOISE
  } run_kind_t;

  typedef struct {
    ttsw_pkg::op_t               op;
    logic [ttsw_pkg::CHAR_W-1:0] data;
    logic [ttsw_pkg::ROW_W-1:0]  row;
    logic [ttsw_pkg::COL_W-1:0]  col;
    bit                          wait_drain;
  } term_op_t;

  typedef struct packed {
    logic [ttsw_pkg::CHAR_W-1:0]     ch;
    logic [ttsw_pkg::COL_W-1:0]      col;
    logic [ttsw_pkg::ROW_W-1:0]      row;
    logic [ttsw_pkg::CUR_ADDR_W-1:0] addr;
  } screen_reply_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  ttsw_pkg::op_t                   operation = ttsw_pkg::OP_WRITE;
  logic [ttsw_pkg::CHAR_W-1:0]     byte_in = '0;
  logic [ttsw_pkg::ROW_W-1:0]      read_row = '0;
  logic [ttsw_pkg::COL_W-1:0]      read_col = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [ttsw_pkg::CHAR_W-1:0]     cell_char;
  logic [ttsw_pkg::COL_W-1:0]      cursor_col;
  logic [ttsw_pkg::ROW_W-1:0]      cursor_row;
  logic [ttsw_pkg::CUR_ADDR_W-1:0] cursor_address;

  term_op_t      term_ops[$];
  screen_reply_t expected_replies[$];
  int            ops_total;
  int            ops_sent = 0;
  int            replies_seen = 0;
  int            errors = 0;
  int            gap_left = 0;
  int            stall_left = 0;
  int            long_left = 0;
  int            cycle_count = 0;
  bit            tx_fast = 1'b0;
  bit            rx_fast = 1'b0;
  bit            drain_next = 1'b0;

  // shadow copy of the screen and cursor
  logic [ttsw_pkg::CHAR_W-1:0] screen_model [ttsw_pkg::CELLS];
  int unsigned                 cur_x;
  int unsigned                 cur_y;

  text_terminal_screen_writer DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .byte_in        (byte_in),
    .read_row       (read_row),
    .read_col       (read_col),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cell_char      (cell_char),
    .cursor_col     (cursor_col),
    .cursor_row     (cursor_row),
    .cursor_address (cursor_address)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // blank screen, cursor home
  function automatic void clear_model();
    for (int i = 0; i < ttsw_pkg::CELLS; i++) screen_model[i] = ttsw_pkg::BLANK;
    cur_x = 0;
    cur_y = 0;
  endfunction

  // newline, scrolling up at the bottom row
  function automatic void line_feed();
    cur_x = 0;
    if (cur_y + 1 >= ttsw_pkg::ROWS) begin
      cur_y = ttsw_pkg::ROWS - 1;
      for (int i = 0; i < ttsw_pkg::COLS * (ttsw_pkg::ROWS - 1); i++) begin
        screen_model[i] = screen_model[i + ttsw_pkg::COLS];
      end
      for (int i = ttsw_pkg::COLS * (ttsw_pkg::ROWS - 1); i < ttsw_pkg::CELLS; i++) begin
        screen_model[i] = ttsw_pkg::BLANK;
      end
    end else begin
      cur_y = cur_y + 1;
    end
  endfunction

  // one step of the terminal, returns the reply it gives
  function automatic screen_reply_t predict_terminal(ttsw_pkg::op_t op,
                                                     logic [ttsw_pkg::CHAR_W-1:0] data,
                                                     logic [ttsw_pkg::ROW_W-1:0] row,
                                                     logic [ttsw_pkg::COL_W-1:0] col);
    screen_reply_t r;
    logic [ttsw_pkg::CHAR_W-1:0] ch;
    ch = '0;
    case (op)
      ttsw_pkg::OP_WRITE: begin
        if (data == ttsw_pkg::CH_LF || data == ttsw_pkg::CH_VT ||
            data == ttsw_pkg::CH_FF) begin
          line_feed();
        end else if (data == ttsw_pkg::CH_CR) begin
          cur_x = 0;
        end else if (data == ttsw_pkg::CH_BS) begin
          if (cur_x > ttsw_pkg::COLS) cur_x = ttsw_pkg::COLS;
          if (cur_x > 0) cur_x = cur_x - 1;
        end else if (data > ttsw_pkg::CH_LAST_CTRL) begin
          // pending wrap takes a newline before the store
          if (cur_x >= ttsw_pkg::COLS) line_feed();
          screen_model[cur_y * ttsw_pkg::COLS + cur_x] = data;
          cur_x = cur_x + 1;
        end
      end
      ttsw_pkg::OP_READ: begin
        if (row < ttsw_pkg::ROWS && col < ttsw_pkg::COLS) begin
          ch = screen_model[row * ttsw_pkg::COLS + col];
        end
      end
      ttsw_pkg::OP_CLEAR: clear_model();
      default: ;
    endcase
    r.ch   = ch;
    r.col  = cur_x[ttsw_pkg::COL_W-1:0];
    r.row  = cur_y[ttsw_pkg::ROW_W-1:0];
    r.addr = ttsw_pkg::CUR_ADDR_W'(cur_y * ttsw_pkg::COLS + cur_x);
    return r;
  endfunction

  function automatic void add_op(ttsw_pkg::op_t op, logic [ttsw_pkg::CHAR_W-1:0] data,
                                 logic [ttsw_pkg::ROW_W-1:0] row,
                                 logic [ttsw_pkg::COL_W-1:0] col);
    term_op_t t;
    t.op         = op;
    t.data       = data;
    t.row        = row;
    t.col        = col;
    t.wait_drain = drain_next;
    drain_next   = 1'b0;
    term_ops.push_back(t);
  endfunction

  // write op with junk in the unused read fields
  function automatic void add_byte(logic [ttsw_pkg::CHAR_W-1:0] data);
    add_op(ttsw_pkg::OP_WRITE, data, ttsw_pkg::ROW_W'($urandom),
           ttsw_pkg::COL_W'($urandom));
  endfunction

  function automatic logic [ttsw_pkg::CHAR_W-1:0] rand_printable();
    if ($urandom_range(0, 6) == 0) return ttsw_pkg::CHAR_W'($urandom_range(128, 255));
    return ttsw_pkg::CHAR_W'($urandom_range(32, 126));
  endfunction

  function automatic logic [ttsw_pkg::CHAR_W-1:0] rand_newline();
    case ($urandom_range(0, 2))
      0: return ttsw_pkg::CH_LF;
      1: return ttsw_pkg::CH_VT;
      default: return ttsw_pkg::CH_FF;
    endcase
  endfunction

  // driver: presents queued items, predicts each accepted one
  always @(posedge clk) begin : drive_items
    bit fire;
    term_op_t nxt;
    fire = in_valid && !in_stall;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (fire) begin
        expected_replies.push_back(predict_terminal(operation, byte_in, read_row, read_col));
        ops_sent <= ops_sent + 1;
      end
      if (in_valid && !fire) begin
        // hold the stalled item
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (term_ops.size() > 0 &&
                   (!term_ops[0].wait_drain || (!fire && ops_sent == replies_seen))) begin
        nxt = term_ops.pop_front();
        in_valid  <= 1'b1;
        operation <= nxt.op;
        byte_in   <= nxt.data;
        read_row  <= nxt.row;
        read_col  <= nxt.col;
        if ($urandom_range(0, 59) == 0) tx_fast = !tx_fast;
        gap_left <= tx_fast ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // one long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin : long_hold
    if (rst) begin
      long_left <= 0;
    end else if (out_valid && !out_stall && replies_seen + 1 == LONG_HOLD_AT) begin
      long_left <= LONG_HOLD_LEN;
    end else if (long_left > 0) begin
      long_left <= long_left - 1;
    end
  end

  // monitor: checks each reply against the oldest prediction
  always @(posedge clk) begin : check_replies
    screen_reply_t want;
    int hold;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      hold = stall_left;
      if (out_valid && !out_stall) begin
        replies_seen <= replies_seen + 1;
        if (expected_replies.size() == 0) begin
          $error("reply with no item outstanding: cell_char %0d cursor %0d,%0d",
                 cell_char, cursor_row, cursor_col);
          errors++;
        end else begin
          want = expected_replies.pop_front();
          if (cell_char !== want.ch) begin
            $error("cell_char expected %0d got %0d", want.ch, cell_char);
            errors++;
          end
          if (cursor_col !== want.col) begin
            $error("cursor_col expected %0d got %0d", want.col, cursor_col);
            errors++;
          end
          if (cursor_row !== want.row) begin
            $error("cursor_row expected %0d got %0d", want.row, cursor_row);
            errors++;
          end
          if (cursor_address !== want.addr) begin
            $error("cursor_address expected %0d got %0d", want.addr, cursor_address);
            errors++;
          end
        end
        if ($urandom_range(0, 59) == 0) rx_fast = !rx_fast;
        hold = rx_fast ? 0 : $urandom_range(0, 4);
      end
      out_stall  <= (hold > 0) || (long_left > 0);
      stall_left <= (hold > 0) ? hold - 1 : 0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int run;
    int n;
    run_kind_t kind;
    int pick;
    clear_model();

    // directed: field extremes, controls, out-of-range reads, unused op
    add_op(ttsw_pkg::OP_READ, 8'h00, 5'd0, 7'd0);
    add_byte(8'd65);
    add_byte(8'd255);
    add_byte(8'd32);
    add_byte(8'd127);
    add_op(ttsw_pkg::OP_READ, 8'hff, 5'd0, 7'd1);
    add_op(ttsw_pkg::OP_READ, 8'h00, 5'd24, 7'd79);
    add_op(ttsw_pkg::OP_READ, 8'h00, 5'd25, 7'd0);
    add_op(ttsw_pkg::OP_READ, 8'hff, 5'd31, 7'd127);
    add_op(ttsw_pkg::OP_READ, 8'h00, 5'd0, 7'd80);
    add_op(OP_UNUSED, 8'hff, 5'd31, 7'd127);
    add_byte(8'd0);
    add_byte(ttsw_pkg::CH_LAST_CTRL);
    add_byte(CH_ESC);
    add_byte(ttsw_pkg::CH_BS);
    add_byte(ttsw_pkg::CH_CR);
    add_byte(ttsw_pkg::CH_BS);
    add_byte(ttsw_pkg::CH_LF);
    add_byte(ttsw_pkg::CH_VT);
    add_byte(ttsw_pkg::CH_FF);
    add_byte(8'd33);
    add_op(ttsw_pkg::OP_CLEAR, 8'h55, 5'd10, 7'd42);
    add_op(ttsw_pkg::OP_READ, 8'haa, 5'd0, 7'd0);

    // random runs; the first three force scroll, wrap, and a backspace after a line of text
    run = 0;
    while (term_ops.size() < 23 + RANDOM_OPS) begin
      if (run < 3) begin
        kind = run_kind_t'(run);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 35)      kind = RUN_TEXT;
        else if (pick < 50) kind = RUN_LINES;
        else if (pick < 60) kind = RUN_EDIT;
        else if (pick < 85) kind = RUN_READS;
        else if (pick < 87) kind = RUN_CLEAR;
        else if (pick < 95) kind = RUN_NOISE;
        else if (pick < 97) kind = RUN_WRAP;
        else if (pick < 98) kind = RUN_WRAP_BS;
        else                kind = RUN_SCROLL;
      end
      // sender pause until everything is back
      if (run == 10 || $urandom_range(0, 24) == 0) drain_next = 1'b1;
      case (kind)
        RUN_SCROLL: begin
          n = $urandom_range(25, 30);
          repeat (n) add_byte(rand_newline());
        end
        RUN_WRAP: begin
          n = $urandom_range(81, 90);
          repeat (n) add_byte(rand_printable());
        end
        RUN_WRAP_BS: begin
          repeat (ttsw_pkg::COLS) add_byte(rand_printable());
          add_byte(ttsw_pkg::CH_BS);
          n = $urandom_range(1, 3);
          repeat (n) add_byte(rand_printable());
        end
        RUN_TEXT: begin
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 20);
          repeat (n) begin
            if ($urandom_range(0, 11) == 0) add_byte(ttsw_pkg::CHAR_W'($urandom_range(0, 31)));
            else add_byte(rand_printable());
          end
        end
        RUN_LINES: begin
          n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
          repeat (n) add_byte(rand_newline());
        end
        RUN_EDIT: begin
          n = $urandom_range(1, 4);
          repeat (n) add_byte(($urandom_range(0, 2) == 0) ? ttsw_pkg::CH_CR : ttsw_pkg::CH_BS);
        end
        RUN_READS: begin
          n = $urandom_range(1, 8);
          repeat (n) begin
            add_op(ttsw_pkg::OP_READ, ttsw_pkg::CHAR_W'($urandom),
                   ($urandom_range(0, 9) == 0) ? ttsw_pkg::ROW_W'($urandom_range(25, 31))
                                               : ttsw_pkg::ROW_W'($urandom_range(0, 24)),
                   ($urandom_range(0, 9) == 0) ? ttsw_pkg::COL_W'($urandom_range(80, 127)) :
                   ($urandom_range(0, 1) == 0) ? ttsw_pkg::COL_W'($urandom_range(0, 15))
                                               : ttsw_pkg::COL_W'($urandom_range(0, 79)));
          end
        end
        RUN_CLEAR: add_op(ttsw_pkg::OP_CLEAR, ttsw_pkg::CHAR_W'($urandom),
                          ttsw_pkg::ROW_W'($urandom), ttsw_pkg::COL_W'($urandom));
        default: begin
          n = $urandom_range(1, 4);
          repeat (n) add_op(ttsw_pkg::op_t'($urandom_range(0, 3)),
                            ttsw_pkg::CHAR_W'($urandom),
                            ttsw_pkg::ROW_W'($urandom), ttsw_pkg::COL_W'($urandom));
        end
      endcase
      run++;
    end
    ops_total = term_ops.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // wait for every reply, then let the block settle
    while (replies_seen != ops_total) @(posedge clk);
    repeat (DRAIN_LATENCY) @(posedge clk);

    if (expected_replies.size() != 0) begin
      $error("%0d predicted replies never arrived", expected_replies.size());
      errors++;
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* text_terminal_screen_writer.f */
+incdir+rtl
rtl/ttsw_pkg.sv
rtl/ttsw_ram.sv
rtl/text_terminal_screen_writer.sv
verif/tb.sv
